>>> src/ipsl_pkg.sv
// shared types, constants and the microprogram of the incremental pi speed loop
package ipsl_pkg;

  // fixed field widths
  localparam int ENC_W      = 32;
  localparam int SPEED_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int SMOOTH_W   = 13;
  localparam int DUTY_W     = 8;
  localparam int ERR_W      = 18;
  localparam int MULB_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // gain format
  localparam int GAIN_BITS = 12;
  localparam int GAIN_ONE  = 4096;

  // register reset values
  localparam logic signed [SPEED_W-1:0] TARGET_RESET = 16'sd0;
  localparam logic [GAIN_W-1:0]         KP_RESET     = 16'd7078;
  localparam logic [GAIN_W-1:0]         KI_RESET     = 16'd297;
  localparam logic [SMOOTH_W-1:0]       SMOOTH_RESET = 13'd2970;
  localparam logic [DUTY_W-1:0]         MAXD_RESET   = 8'd199;

  // control store geometry
  localparam int STEP_W      = 3;
  localparam int UCODE_DEPTH = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET   = 3'd0,
    REG_KP       = 3'd1,
    REG_KI       = 3'd2,
    REG_SMOOTH   = 3'd3,
    REG_MAX_DUTY = 3'd4
  } ipsl_reg_e;

  typedef enum logic [2:0] {
    ALU_NONE,
    ALU_SPEED,
    ALU_ERR,
    ALU_CAND,
    ALU_FINAL
  } ipsl_alu_e;

  typedef enum logic [1:0] {
    A_DERR,
    A_ERR,
    A_CAND,
    A_DRIVE
  } ipsl_mula_e;

  typedef enum logic [1:0] {
    B_KP,
    B_KI,
    B_SMOOTH,
    B_REST
  } ipsl_mulb_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } ipsl_acc_e;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_INPUT,
    COND_OUT_FREE
  } ipsl_cond_e;

  typedef struct packed {
    ipsl_alu_e         alu;
    ipsl_mula_e        a_sel;
    ipsl_mulb_e        b_sel;
    ipsl_acc_e         acc;
    ipsl_cond_e        cond;
    logic [STEP_W-1:0] jmp;
  } ipsl_uword_t;

  typedef struct packed {
    ipsl_uword_t uw;
    logic        fire;
  } ipsl_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } ipsl_status_t;

  // microprogram: one control word per step, jump taken when the condition holds
  localparam ipsl_uword_t UCODE [UCODE_DEPTH] = '{
    '{ALU_SPEED, A_DERR,  B_KP,     ACC_HOLD, COND_INPUT,    STEP_W'(1)},
    '{ALU_ERR,   A_DERR,  B_KP,     ACC_HOLD, COND_ALWAYS,   STEP_W'(2)},
    '{ALU_NONE,  A_DERR,  B_KP,     ACC_LOAD, COND_ALWAYS,   STEP_W'(3)},
    '{ALU_NONE,  A_ERR,   B_KI,     ACC_ADD,  COND_ALWAYS,   STEP_W'(4)},
    '{ALU_CAND,  A_ERR,   B_KI,     ACC_HOLD, COND_ALWAYS,   STEP_W'(5)},
    '{ALU_NONE,  A_CAND,  B_SMOOTH, ACC_LOAD, COND_ALWAYS,   STEP_W'(6)},
    '{ALU_NONE,  A_DRIVE, B_REST,   ACC_ADD,  COND_ALWAYS,   STEP_W'(7)},
    '{ALU_FINAL, A_DRIVE, B_REST,   ACC_HOLD, COND_OUT_FREE, STEP_W'(0)}
  };

endpackage

>>> src/ipsl_sequencer.sv
// step counter and control store lookup of the speed loop microprogram
module ipsl_sequencer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ipsl_pkg::ipsl_status_t status_i,
  output ipsl_pkg::ipsl_ctrl_t   ctrl_o
);
  import ipsl_pkg::*;

  logic [STEP_W-1:0] step_q;
  logic [STEP_W-1:0] step_d;
  ipsl_uword_t       uw;
  logic              fire;

  // fetch the control word and evaluate its jump condition
  always_comb begin
    uw = UCODE[step_q];
    unique case (uw.cond)
      COND_ALWAYS:   fire = 1'b1;
      COND_INPUT:    fire = status_i.in_valid;
      COND_OUT_FREE: fire = status_i.out_free;
      default:       fire = 1'b0;
    endcase
  end

  // jump when the condition holds, otherwise stay on this step
  always_comb begin
    step_d = fire ? uw.jmp : step_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o.uw   = uw;
  assign ctrl_o.fire = fire;

endmodule

>>> src/ipsl_datapath.sv
// registers, shared multiplier, accumulator and output register of the speed loop
module ipsl_datapath #(
  parameter int FRAC_BITS   = 12,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [ipsl_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [ipsl_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic signed [ipsl_pkg::ENC_W-1:0]       encoder_count_i,
  input  ipsl_pkg::ipsl_ctrl_t                    ctrl_i,
  input  logic                                    out_ready_i,
  output logic                                    out_valid_o,
  output logic [ipsl_pkg::DUTY_W-1:0]             duty_o,
  output logic                                    direction_o,
  output logic                                    brake_o,
  output logic signed [ipsl_pkg::SPEED_W-1:0]     measured_speed_o
);
  import ipsl_pkg::*;

  // drive word: sign, eight duty bits, fraction
  localparam int DW    = FRAC_BITS + 9;
  localparam int AW    = (DW > ERR_W) ? DW : ERR_W;
  localparam int PW    = AW + MULB_W;
  localparam int ACC_W = PW + 1;
  localparam int CW    = FRAC_BITS + 24;
  localparam int SW    = ACC_W + 4;
  localparam int UP    = (FRAC_BITS >= GAIN_BITS) ? FRAC_BITS - GAIN_BITS : 0;
  localparam int DN    = (FRAC_BITS < GAIN_BITS) ? GAIN_BITS - FRAC_BITS : 0;
  localparam logic signed [COUNT_WIDTH:0] SPD_MAX = (COUNT_WIDTH + 1)'(32767);
  localparam logic signed [COUNT_WIDTH:0] SPD_MIN = (COUNT_WIDTH + 1)'(-32768);

  // configuration registers
  logic signed [SPEED_W-1:0] target_q;
  logic [GAIN_W-1:0]         kp_q;
  logic [GAIN_W-1:0]         ki_q;
  logic [SMOOTH_W-1:0]       smooth_q;
  logic [DUTY_W-1:0]         maxd_q;

  // loop state
  logic [COUNT_WIDTH-1:0]    prev_count_q;
  logic signed [ERR_W-1:0]   prev_err_q;
  logic signed [DW-1:0]      drive_q;
  logic                      brake_q;

  // working registers
  logic signed [SPEED_W-1:0] speed_q;
  logic signed [ERR_W-1:0]   err_q;
  logic signed [ERR_W-1:0]   derr_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [DW-1:0]      cand_q;

  // output register
  logic                      out_valid_q;
  logic [DUTY_W-1:0]         duty_q;
  logic                      dir_q;
  logic signed [SPEED_W-1:0] speed_out_q;

  logic [COUNT_WIDTH-1:0]    enc_cur;
  logic [COUNT_WIDTH-1:0]    diff;
  logic signed [COUNT_WIDTH:0] diff_x;
  logic signed [SPEED_W-1:0] speed_d;
  logic signed [ERR_W-1:0]   err_d;
  logic signed [ERR_W-1:0]   derr_d;
  logic [SMOOTH_W-1:0]       s_sat;
  logic signed [AW-1:0]      mul_a;
  logic signed [MULB_W-1:0]  mul_b;
  logic signed [PW-1:0]      prod;
  logic signed [SW-1:0]      acc_x;
  logic signed [SW-1:0]      scaled_x;
  logic signed [CW-1:0]      cand_sum;
  logic signed [CW-1:0]      lim;
  logic signed [CW-1:0]      neg_lim;
  logic signed [CW-1:0]      cand_c;
  logic signed [ACC_W-1:0]   blend_x;
  logic signed [DW-1:0]      blended;
  logic signed [DW-1:0]      mag;
  logic                      pos;
  logic [DUTY_W-1:0]         duty_d;
  logic                      standstill;
  logic signed [DW-1:0]      drive_d;
  logic                      brake_d;
  logic                      do_speed;
  logic                      do_final;

  assign do_speed = ctrl_i.fire && (ctrl_i.uw.alu == ALU_SPEED);
  assign do_final = ctrl_i.fire && (ctrl_i.uw.alu == ALU_FINAL);

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RESET;
      kp_q     <= KP_RESET;
      ki_q     <= KI_RESET;
      smooth_q <= SMOOTH_RESET;
      maxd_q   <= MAXD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TARGET:   target_q <= cfg_data_i;
        REG_KP:       kp_q     <= cfg_data_i;
        REG_KI:       ki_q     <= cfg_data_i;
        REG_SMOOTH:   smooth_q <= cfg_data_i[SMOOTH_W-1:0];
        REG_MAX_DUTY: maxd_q   <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // wrapped count difference, saturated to the speed range
  always_comb begin
    enc_cur = encoder_count_i[COUNT_WIDTH-1:0];
    diff    = enc_cur - prev_count_q;
    diff_x  = {diff[COUNT_WIDTH-1], diff};
    if (diff_x > SPD_MAX) begin
      speed_d = SPD_MAX[SPEED_W-1:0];
    end else if (diff_x < SPD_MIN) begin
      speed_d = SPD_MIN[SPEED_W-1:0];
    end else begin
      speed_d = diff_x[SPEED_W-1:0];
    end
  end

  // error and change in error
  always_comb begin
    err_d  = ERR_W'(target_q) - ERR_W'(speed_q);
    derr_d = err_d - prev_err_q;
  end

  // shared multiplier operand selection
  always_comb begin
    s_sat = (smooth_q > SMOOTH_W'(GAIN_ONE)) ? SMOOTH_W'(GAIN_ONE) : smooth_q;
    unique case (ctrl_i.uw.a_sel)
      A_DERR:  mul_a = AW'(derr_q);
      A_ERR:   mul_a = AW'(err_q);
      A_CAND:  mul_a = AW'(cand_q);
      A_DRIVE: mul_a = AW'(drive_q);
      default: mul_a = '0;
    endcase
    unique case (ctrl_i.uw.b_sel)
      B_KP:     mul_b = {1'b0, kp_q};
      B_KI:     mul_b = {1'b0, ki_q};
      B_SMOOTH: mul_b = MULB_W'(s_sat);
      B_REST:   mul_b = MULB_W'(SMOOTH_W'(GAIN_ONE) - s_sat);
      default:  mul_b = '0;
    endcase
    prod = mul_a * mul_b;
  end

  // rescale the increment, add to the drive and clamp
  always_comb begin
    acc_x    = SW'(acc_q);
    scaled_x = (acc_x <<< UP) >>> DN;
    cand_sum = CW'(drive_q) + $signed(scaled_x[CW-1:0]);
    lim      = CW'({maxd_q, FRAC_BITS'(0)});
    neg_lim  = -lim;
    if (cand_sum > lim) begin
      cand_c = lim;
    end else if (cand_sum < neg_lim) begin
      cand_c = neg_lim;
    end else begin
      cand_c = cand_sum;
    end
  end

  // blended drive, duty, direction and brake
  always_comb begin
    blend_x    = acc_q >>> GAIN_BITS;
    blended    = blend_x[DW-1:0];
    pos        = !blended[DW-1] && (blended != '0);
    mag        = blended[DW-1] ? -blended : blended;
    duty_d     = mag[FRAC_BITS +: DUTY_W];
    standstill = (target_q == '0) && (speed_q == '0);
    drive_d    = standstill ? '0 : blended;
    if (standstill) begin
      brake_d = 1'b1;
    end else if (duty_d != '0) begin
      brake_d = 1'b0;
    end else begin
      brake_d = brake_q;
    end
  end

  // loop state, updated when a count is taken and at the final step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q <= '0;
      prev_err_q   <= '0;
      drive_q      <= '0;
      brake_q      <= 1'b1;
    end else begin
      if (do_speed) begin
        prev_count_q <= enc_cur;
      end
      if (do_final) begin
        prev_err_q <= err_q;
        drive_q    <= drive_d;
        brake_q    <= brake_d;
      end
    end
  end

  // working registers driven by the control word
  always_ff @(posedge clk_i) begin
    if (do_speed) begin
      speed_q <= speed_d;
    end
    if (ctrl_i.fire && (ctrl_i.uw.alu == ALU_ERR)) begin
      err_q  <= err_d;
      derr_q <= derr_d;
    end
    if (ctrl_i.fire && (ctrl_i.uw.alu == ALU_CAND)) begin
      cand_q <= cand_c[DW-1:0];
    end
    unique case (ctrl_i.uw.acc)
      ACC_LOAD: acc_q <= ACC_W'(prod);
      ACC_ADD:  acc_q <= acc_q + ACC_W'(prod);
      default: ;
    endcase
    if (do_final) begin
      duty_q      <= duty_d;
      dir_q       <= pos;
      speed_out_q <= speed_q;
    end
  end

  // result transfer flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_final) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign duty_o           = duty_q;
  assign direction_o      = dir_q;
  assign brake_o          = brake_q;
  assign measured_speed_o = speed_out_q;

endmodule

>>> src/incremental_pi_speed_loop.sv
// top level of the incremental pi speed loop
//
//   channel   signals                                       direction
//   input     in_valid_i / in_ready_o, encoder_count_i       in
//   result    out_valid_o / out_ready_i, duty_o, direction_o,
//             brake_o, measured_speed_o                      out
//   config    cfg_we_i, cfg_index_i, cfg_data_i              in, write only
//
// an eight step microprogram runs each tick on one shared 21x17 signed multiplier:
// four multiply steps plus count, error, clamp and finish steps
// a count is taken at step zero; its result is loaded at the finish step, and the
// next count is taken only once the sequencer has returned to step zero
// the finish step waits while the previous result is still not taken
// reset restores the register defaults, clears the loop state and engages the brake
module incremental_pi_speed_loop #(
  parameter int FRAC_BITS   = 12,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ipsl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ipsl_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [ipsl_pkg::ENC_W-1:0]   encoder_count_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ipsl_pkg::DUTY_W-1:0]         duty_o,
  output logic                                direction_o,
  output logic                                brake_o,
  output logic signed [ipsl_pkg::SPEED_W-1:0] measured_speed_o
);
  import ipsl_pkg::*;

  ipsl_status_t status;
  ipsl_ctrl_t   ctrl;
  logic         out_valid;

  // conditions seen by the sequencer
  assign status.in_valid = in_valid_i;
  assign status.out_free = !out_valid || out_ready_i;

  // the count step is the only one that takes an input transfer
  assign in_ready_o  = (ctrl.uw.alu == ALU_SPEED);
  assign out_valid_o = out_valid;

  ipsl_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  ipsl_datapath #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .encoder_count_i  (encoder_count_i),
    .ctrl_i           (ctrl),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid),
    .duty_o           (duty_o),
    .direction_o      (direction_o),
    .brake_o          (brake_o),
    .measured_speed_o (measured_speed_o)
  );

endmodule

>>> src/ipsl_checker.sv
// port level checks of the speed loop and their binding to the top level
module ipsl_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [ipsl_pkg::DUTY_W-1:0]         duty_o,
  input logic                                direction_o,
  input logic                                brake_o,
  input logic signed [ipsl_pkg::SPEED_W-1:0] measured_speed_o
);

  // a pending input stays offered
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("input valid dropped before transfer");

  // a pending result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(duty_o) &&
      $stable(direction_o) && $stable(brake_o) && $stable(measured_speed_o))
    else $error("result changed before transfer");

  // one tick at a time: ready drops after each input transfer
  a_one_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a tick is in progress");

  // a nonzero duty while moving always releases the brake
  a_brake_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (duty_o != '0) && (measured_speed_o != '0) |-> !brake_o)
    else $error("brake held with nonzero duty while moving");

endmodule

bind incremental_pi_speed_loop ipsl_checker u_chk (.*);
